// File: rtl/kfl_pkg.sv
// shared types and constants for the keyed free-list slot allocator
package kfl_pkg;

    localparam int MAX_SLOTS = 64;
    localparam int SLOT_W    = 6;
    localparam int COUNT_W   = 7;
    localparam int KEY_W     = 10;

    localparam logic [COUNT_W-1:0] POOL_MAX = COUNT_W'(MAX_SLOTS);
    localparam logic [COUNT_W-1:0] POOL_MIN = COUNT_W'(1);

    typedef enum logic [1:0] {
        ACT_ACQUIRE = 2'd0,
        ACT_RELEASE = 2'd1,
        ACT_LOOKUP  = 2'd2,
        ACT_NOP     = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_RANGE    = 2'd2,
        ST_UNMAPPED = 2'd3
    } status_t;

endpackage

// File: rtl/keyed_free_list_slot_allocator_top.sv
// keyed free-list slot allocator: lifo slot pool with a key-to-slot map
//
// usage:
//   s_ channel carries one operation per transfer: s_tuser is the action
//   (acquire, release, lookup, no-op) and s_tdata holds the connection key.
//   m_ channel returns exactly one result per operation, in order.
//   cfg channel writes the pool size; cfg_ready is always high. a write
//   rebuilds the free chain 0..size-1 and clears the key map; the user must
//   issue it only while no operation is in flight; the block does not enforce it.
// pipeline and throughput:
//   one operation per cycle while the result register can drain. an operation
//   is registered at acceptance, together with the registered map read for its
//   key, and its result is registered in the result register when it proceeds.
//   the rate is set by the update of the free-list head, whose next link is
//   kept prefetched in a register from the link memory.
// reset:
//   aresetn low gives a pool of 64 slots, free chain 0..63, empty map and
//   empty pipeline. no initialization sweep is needed.
// stall:
//   with m_tready low one further operation is taken into the input
//   register, then s_tready drops until the result register drains.
module keyed_free_list_slot_allocator_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [9:0] conn_key, [15:10] zero
    input  logic [1:0]  s_tuser,   // [1:0] action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [5:0] slot_index, [7:6] status, [14:8] free_slots, [15] zero
    output logic        m_tuser,   // [0] slot_valid
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [6:0]  cfg_data   // pool_slots
);

    localparam int SW = kfl_pkg::SLOT_W;
    localparam int CW = kfl_pkg::COUNT_W;
    localparam int KW = kfl_pkg::KEY_W;
    localparam int NS = kfl_pkg::MAX_SLOTS;

    // input register
    logic                  in_valid_reg;
    kfl_pkg::action_t      in_action_reg;
    logic [KW-1:0]         in_key_reg;
    logic [SW-1:0]         map_rd_reg;

    // allocator state
    logic [CW-1:0]         pool_reg;
    logic [SW-1:0]         head_reg;
    logic [SW-1:0]         head_next;
    logic [CW-1:0]         total_reg;
    logic [CW-1:0]         total_next;
    logic [SW-1:0]         link_rd_reg;
    logic [NS-1:0]         map_valid_reg;
    logic [NS-1:0]         link_valid_reg;
    logic [SW-1:0]         link_mem [NS];
    logic [SW-1:0]         map_mem  [NS];

    // result register
    logic                  m_valid_reg;
    logic [SW-1:0]         m_slot_reg;
    logic                  m_slot_valid_reg;
    kfl_pkg::status_t      m_status_reg;
    logic [CW-1:0]         m_free_reg;

    logic                  proceed;
    logic                  s_accept;
    logic                  cfg_write;
    logic [CW-1:0]         cfg_pool;
    logic [SW-1:0]         key_idx;
    logic [SW-1:0]         s_key_idx;
    logic                  in_range;
    logic [SW-1:0]         res_slot;
    logic                  res_valid;
    kfl_pkg::status_t      res_status;
    logic                  map_set;
    logic                  map_clr;
    logic                  link_we;
    logic                  pop_ok;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid & cfg_ready;
    assign proceed   = in_valid_reg & (~m_valid_reg | m_tready);
    assign s_tready  = ~in_valid_reg | proceed;
    assign s_accept  = s_tvalid & s_tready;
    assign key_idx   = in_key_reg[SW-1:0];
    assign s_key_idx = s_tdata[SW-1:0];
    assign in_range  = in_key_reg < {{(KW-CW){1'b0}}, pool_reg};

    always_comb begin
        if (cfg_data == '0) begin
            cfg_pool = kfl_pkg::POOL_MIN;
        end else if (cfg_data > kfl_pkg::POOL_MAX) begin
            cfg_pool = kfl_pkg::POOL_MAX;
        end else begin
            cfg_pool = cfg_data;
        end
    end

    // operation logic
    always_comb begin
        res_slot   = '0;
        res_valid  = 1'b0;
        res_status = kfl_pkg::ST_OK;
        head_next  = head_reg;
        total_next = total_reg;
        map_set    = 1'b0;
        map_clr    = 1'b0;
        link_we    = 1'b0;
        pop_ok     = 1'b0;
        if (in_action_reg == kfl_pkg::ACT_NOP) begin
            res_status = kfl_pkg::ST_OK;
        end else if (!in_range) begin
            res_status = kfl_pkg::ST_RANGE;
        end else if (in_action_reg == kfl_pkg::ACT_ACQUIRE) begin
            if (total_reg == '0) begin
                res_status = kfl_pkg::ST_EMPTY;
            end else begin
                pop_ok     = 1'b1;
                res_slot   = head_reg;
                res_valid  = 1'b1;
                head_next  = link_rd_reg;
                total_next = total_reg - CW'(1);
                map_set    = 1'b1;
            end
        end else if (!map_valid_reg[key_idx]) begin
            res_status = kfl_pkg::ST_UNMAPPED;
        end else begin
            res_slot  = map_rd_reg;
            res_valid = 1'b1;
            if (in_action_reg == kfl_pkg::ACT_RELEASE) begin
                link_we   = 1'b1;
                head_next = map_rd_reg;
                map_clr   = 1'b1;
                if (total_reg < pool_reg) begin
                    total_next = total_reg + CW'(1);
                end
            end
        end
    end

    // input register and map read
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_accept) begin
            in_valid_reg <= 1'b1;
        end else if (proceed) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_action_reg <= kfl_pkg::action_t'(s_tuser);
            in_key_reg    <= s_tdata[KW-1:0];
            if (proceed && map_set && key_idx == s_key_idx) begin
                map_rd_reg <= head_reg;
            end else begin
                map_rd_reg <= map_mem[s_key_idx];
            end
        end
    end

    // memories
    always_ff @(posedge aclk) begin
        if (proceed && map_set) begin
            map_mem[key_idx] <= head_reg;
        end
        if (proceed && link_we) begin
            link_mem[map_rd_reg] <= head_reg;
        end
    end

    // control state and link prefetch
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pool_reg       <= kfl_pkg::POOL_MAX;
            head_reg       <= '0;
            total_reg      <= kfl_pkg::POOL_MAX;
            link_rd_reg    <= SW'(1);
            map_valid_reg  <= '0;
            link_valid_reg <= '0;
        end else if (cfg_write) begin
            pool_reg       <= cfg_pool;
            head_reg       <= '0;
            total_reg      <= cfg_pool;
            link_rd_reg    <= SW'(1);
            map_valid_reg  <= '0;
            link_valid_reg <= '0;
        end else if (proceed) begin
            head_reg  <= head_next;
            total_reg <= total_next;
            if (map_set) begin
                map_valid_reg[key_idx] <= 1'b1;
            end
            if (map_clr) begin
                map_valid_reg[key_idx] <= 1'b0;
            end
            if (link_we) begin
                link_valid_reg[map_rd_reg] <= 1'b1;
            end
            if (link_we && map_rd_reg == head_next) begin
                link_rd_reg <= head_reg;
            end else if (link_valid_reg[head_next]) begin
                link_rd_reg <= link_mem[head_next];
            end else begin
                link_rd_reg <= head_next + SW'(1);
            end
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (proceed) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (proceed) begin
            m_slot_reg       <= res_slot;
            m_slot_valid_reg <= res_valid;
            m_status_reg     <= res_status;
            m_free_reg       <= total_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_slot_valid_reg;
    assign m_tdata  = {1'b0, m_free_reg, m_status_reg, m_slot_reg};

    a_total_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        total_reg <= pool_reg)
        else $error("free count exceeds pool size");

    a_pop_counts: assert property (@(posedge aclk) disable iff (!aresetn)
        proceed && pop_ok && !cfg_write |=> total_reg == $past(total_reg) - CW'(1))
        else $error("acquire did not take one slot from the pool");

    a_valid_means_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_slot_valid_reg |-> m_status_reg == kfl_pkg::ST_OK)
        else $error("slot reported with an error status");

    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_status_reg == kfl_pkg::ST_EMPTY |-> m_free_reg == '0)
        else $error("pool empty reported with free slots left");

    a_cfg_rebuild: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_write |=> head_reg == '0 && total_reg == pool_reg && map_valid_reg == '0)
        else $error("pool size write did not rebuild the free list");

endmodule

// File: bench/keyed_free_list_slot_allocator_top_tb.sv
// testbench for the keyed free-list slot allocator: random and directed traffic checked by a scoreboard
`timescale 1ns / 100ps

module keyed_free_list_slot_allocator_top_tb;

    localparam int CYCLE_LIMIT = 200000;
    localparam int SETTLE_CYCLES = 4;
    localparam int MAX_REPORTS = 30;

    typedef struct packed {
        logic [kfl_pkg::SLOT_W-1:0]  slot_index;
        logic                        slot_valid;
        kfl_pkg::status_t            status;
        logic [kfl_pkg::COUNT_W-1:0] free_slots;
    } slot_result_t;

    class slot_pool_scoreboard;
        logic [kfl_pkg::COUNT_W-1:0] pool_size;
        logic [kfl_pkg::SLOT_W-1:0]  next_free [kfl_pkg::MAX_SLOTS];
        logic [kfl_pkg::SLOT_W-1:0]  head;
        logic [kfl_pkg::COUNT_W-1:0] avail_count;
        logic                        key_held [kfl_pkg::MAX_SLOTS];
        logic [kfl_pkg::SLOT_W-1:0]  key_slot [kfl_pkg::MAX_SLOTS];
        slot_result_t                expected_q [$];
        int                          fail_count;

        function new();
            pool_size = kfl_pkg::POOL_MAX;
            fail_count = 0;
            rebuild();
        endfunction

        function void rebuild();
            for (int i = 0; i < kfl_pkg::MAX_SLOTS; i++) begin
                next_free[i] = kfl_pkg::SLOT_W'(i + 1);
                key_held[i] = 1'b0;
                key_slot[i] = '0;
            end
            head = '0;
            avail_count = pool_size;
        endfunction

        function void configure(logic [kfl_pkg::COUNT_W-1:0] value);
            if (value == '0)
                pool_size = kfl_pkg::POOL_MIN;
            else if (value > kfl_pkg::POOL_MAX)
                pool_size = kfl_pkg::POOL_MAX;
            else
                pool_size = value;
            rebuild();
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // predicts the result of one accepted operation and updates the pool
        function void note_op(kfl_pkg::action_t act, logic [kfl_pkg::KEY_W-1:0] key);
            slot_result_t r;
            logic [kfl_pkg::SLOT_W-1:0] slot;
            logic [kfl_pkg::SLOT_W-1:0] k;
            r = '0;
            r.status = kfl_pkg::ST_OK;
            k = key[kfl_pkg::SLOT_W-1:0];
            if (act == kfl_pkg::ACT_NOP) begin
                // no-op leaves everything as is
            end else if (key >= kfl_pkg::KEY_W'(pool_size)) begin
                r.status = kfl_pkg::ST_RANGE;
            end else if (act == kfl_pkg::ACT_ACQUIRE) begin
                if (avail_count == '0) begin
                    r.status = kfl_pkg::ST_EMPTY;
                end else begin
                    slot = head;
                    head = next_free[slot];
                    avail_count = avail_count - 1'b1;
                    key_held[k] = 1'b1;
                    key_slot[k] = slot;
                    r.slot_index = slot;
                    r.slot_valid = 1'b1;
                end
            end else if (!key_held[k]) begin
                r.status = kfl_pkg::ST_UNMAPPED;
            end else begin
                slot = key_slot[k];
                if (act == kfl_pkg::ACT_RELEASE) begin
                    next_free[slot] = head;
                    head = slot;
                    if (avail_count < pool_size)
                        avail_count = avail_count + 1'b1;
                    key_held[k] = 1'b0;
                    key_slot[k] = '0;
                end
                r.slot_index = slot;
                r.slot_valid = 1'b1;
            end
            r.free_slots = avail_count;
            expected_q.push_back(r);
        endfunction

        task report(string msg);
            if (fail_count < MAX_REPORTS)
                $display("mismatch at %0t: %s", $time, msg);
            fail_count++;
        endtask

        task check(slot_result_t got);
            slot_result_t exp;
            if (expected_q.size() == 0) begin
                report("result transfer with nothing expected");
            end else begin
                exp = expected_q.pop_front();
                if (got.slot_index != exp.slot_index)
                    report($sformatf("slot_index got %0d expected %0d",
                                     got.slot_index, exp.slot_index));
                if (got.slot_valid != exp.slot_valid)
                    report($sformatf("slot_valid got %0d expected %0d",
                                     got.slot_valid, exp.slot_valid));
                if (got.status != exp.status)
                    report($sformatf("status got %0d expected %0d",
                                     got.status, exp.status));
                if (got.free_slots != exp.free_slots)
                    report($sformatf("free_slots got %0d expected %0d",
                                     got.free_slots, exp.free_slots));
            end
        endtask
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;   // [9:0] conn_key, [15:10] zero
    logic [1:0]  s_tuser = '0;   // [1:0] action
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;        // [5:0] slot_index, [7:6] status, [14:8] free_slots, [15] zero
    logic        m_tuser;        // [0] slot_valid
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [6:0]  cfg_data = '0;

    slot_pool_scoreboard sb = new();
    bit calm = 1'b0;
    int cycles = 0;

    keyed_free_list_slot_allocator_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // mostly short gaps, a few long ones, none in calm phases
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(4, 20);
    endfunction

    // result side: random back-pressure and checking
    initial begin
        int stall;
        stall = 0;
        forever begin
            @(posedge aclk);
            if (m_tvalid && m_tready)
                sb.check('{slot_index: m_tdata[5:0], slot_valid: m_tuser,
                           status: kfl_pkg::status_t'(m_tdata[7:6]),
                           free_slots: m_tdata[14:8]});
            if (stall > 0) begin
                m_tready <= 1'b0;
                stall--;
            end else begin
                m_tready <= 1'b1;
                stall = pick_gap();
            end
        end
    end

    task automatic send_op(input kfl_pkg::action_t act,
                           input logic [kfl_pkg::KEY_W-1:0] key);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= act;
        s_tdata <= {6'd0, key};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_op(act, key);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_pool(input logic [6:0] value);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_data <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        sb.configure(value);
    endtask

    task automatic run_traffic(input int count, input int acquire_pct);
        int r;
        int k;
        kfl_pkg::action_t act;
        logic [kfl_pkg::KEY_W-1:0] key;
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(0, 99);
            if (r < acquire_pct)
                act = kfl_pkg::ACT_ACQUIRE;
            else if (r < 80)
                act = kfl_pkg::ACT_RELEASE;
            else if (r < 95)
                act = kfl_pkg::ACT_LOOKUP;
            else
                act = kfl_pkg::ACT_NOP;
            k = $urandom_range(0, 99);
            if (k < 6)
                key = kfl_pkg::KEY_W'($urandom_range(0, 1023));
            else if (k < 9)
                key = kfl_pkg::KEY_W'(sb.pool_size) + kfl_pkg::KEY_W'($urandom_range(0, 3));
            else
                key = kfl_pkg::KEY_W'($urandom_range(0, sb.pool_size - 1));
            send_op(act, key);
        end
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: full pool after reset
        send_op(kfl_pkg::ACT_ACQUIRE, 10'd0);
        send_op(kfl_pkg::ACT_ACQUIRE, 10'd63);
        send_op(kfl_pkg::ACT_LOOKUP, 10'd0);
        send_op(kfl_pkg::ACT_LOOKUP, 10'd63);
        send_op(kfl_pkg::ACT_RELEASE, 10'd0);
        send_op(kfl_pkg::ACT_RELEASE, 10'd0);
        send_op(kfl_pkg::ACT_LOOKUP, 10'd5);
        send_op(kfl_pkg::ACT_ACQUIRE, 10'd63);
        send_op(kfl_pkg::ACT_RELEASE, 10'd63);
        send_op(kfl_pkg::ACT_ACQUIRE, 10'd64);
        send_op(kfl_pkg::ACT_LOOKUP, 10'd1023);
        send_op(kfl_pkg::ACT_RELEASE, 10'd1023);
        send_op(kfl_pkg::ACT_NOP, 10'd1023);
        send_op(kfl_pkg::ACT_NOP, 10'd0);

        // directed: single slot pool, empty pool
        write_pool(7'd1);
        send_op(kfl_pkg::ACT_ACQUIRE, 10'd0);
        send_op(kfl_pkg::ACT_ACQUIRE, 10'd0);
        send_op(kfl_pkg::ACT_LOOKUP, 10'd0);
        send_op(kfl_pkg::ACT_RELEASE, 10'd0);
        send_op(kfl_pkg::ACT_ACQUIRE, 10'd1);

        // directed: register values clamped
        write_pool(7'd0);
        send_op(kfl_pkg::ACT_ACQUIRE, 10'd0);
        write_pool(7'd127);
        send_op(kfl_pkg::ACT_LOOKUP, 10'd0);
        send_op(kfl_pkg::ACT_ACQUIRE, 10'd63);

        // random phases
        write_pool(7'd2);
        run_traffic(60, 45);
        write_pool(7'd65);
        run_traffic(45, 65);
        drain_results();
        run_traffic(45, 40);
        write_pool(7'd64);
        calm = 1'b1;
        run_traffic(60, 45);
        calm = 1'b0;
        write_pool(7'd7);
        run_traffic(70, 45);
        write_pool(7'd1);
        run_traffic(40, 50);
        write_pool(7'($urandom_range(1, 64)));
        run_traffic(70, 45);
        write_pool(7'd33);
        run_traffic(60, 55);

        drain_results();
        repeat (10) @(posedge aclk);
        if (sb.fail_count == 0 && sb.pending() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
